[rtl/lcar_pkg.sv]
`timescale 1ns / 1ps

package lcar_pkg;

    // Port and register widths
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CAL_W      = 16;
    localparam int COUNT_W    = 8;
    localparam int RAW_W      = 24;
    localparam int WEIGHT_W   = 33;

    // Request codes carried on the action field
    localparam logic [ACT_W-1:0] ACT_MEASURE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TARE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DOWN    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UP      = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCOUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TCOUNT = 2'd2;

    // Configuration reset values
    localparam logic signed [CAL_W-1:0] CAL_RESET    = -16'sd781;
    localparam logic [COUNT_W-1:0]      SCOUNT_RESET = 8'd10;
    localparam logic [COUNT_W-1:0]      TCOUNT_RESET = 8'd20;

    // Converter serial protocol phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_DOWN
    } phase_t;

    // Request sequencer: tick handling and the two divisions at completion
    typedef enum logic [2:0] {
        SQ_TICK,
        SQ_Q8_GO,
        SQ_Q8_RUN,
        SQ_WT_GO,
        SQ_WT_RUN
    } seq_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic               start;
        logic [ACT_W-1:0]   req;
        logic               frame;
        logic               bit_step;
        logic               accum;
        logic               q8_go;
        logic               take_q8;
        logic               set_tare;
        logic               set_zero;
        logic               wt_go;
        logic               take_wt;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic bit_last;
        logic sample_last;
        logic div_done;
        logic cal_zero;
    } dp_stat_t;

endpackage

[rtl/lcar_div.sv]
`timescale 1ns / 1ps

module lcar_div #(
    parameter int W = 41
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [W-1:0]           dividend,
    input  logic signed [lcar_pkg::CAL_W-1:0] divisor,
    output logic signed [W-1:0]           quotient,
    output logic                          done
);
    import lcar_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]       q_reg, q_next;
    logic [CAL_W-1:0]   rem_reg, rem_next;
    logic [CAL_W-1:0]   dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    logic [CAL_W:0]     rem_shift;
    logic [CAL_W:0]     rem_sub;
    logic               fits;

    // One restoring step on the magnitudes
    assign rem_shift = {rem_reg, q_reg[W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend[W-1] ? W'(-dividend) : W'(dividend);
            dvs_next = divisor[CAL_W-1] ? CAL_W'(-divisor) : CAL_W'(divisor);
            neg_next = dividend[W-1] ^ divisor[CAL_W-1];
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[W-2:0], fits};
            rem_next = fits ? rem_sub[CAL_W-1:0] : rem_shift[CAL_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Apply the sign of the result
    assign quotient = neg_reg ? $signed(-q_reg) : $signed(q_reg);
    assign done     = done_reg;

endmodule

[rtl/lcar_dp.sv]
`timescale 1ns / 1ps

module lcar_dp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lcar_pkg::dp_cmd_t                     cmd,
    output lcar_pkg::dp_stat_t                    stat,
    input  logic                                  data_level,
    input  logic                                  cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic signed [lcar_pkg::RAW_W-1:0]     raw_average,
    output logic signed [lcar_pkg::WEIGHT_W-1:0]  weight,
    output logic                                  divide_error
);
    import lcar_pkg::*;

    localparam int BC_W  = $clog2(SAMPLE_BITS + 2);
    localparam int SUM_W = SAMPLE_BITS + COUNT_W;
    localparam int DVD_W = SAMPLE_BITS + 17;
    localparam int EXT_W = (DVD_W > 34) ? DVD_W : 34;
    localparam logic signed [EXT_W-1:0] W_MAX = EXT_W'(64'sd4294967295);
    localparam logic signed [EXT_W-1:0] W_MIN = EXT_W'(-64'sd4294967296);

    // Configuration registers
    logic signed [CAL_W-1:0]    cal_reg;
    logic [COUNT_W-1:0]         scount_reg;
    logic [COUNT_W-1:0]         tcount_reg;

    // Conversion state
    logic [SAMPLE_BITS-1:0]     shift_reg, shift_next;
    logic [BC_W-1:0]            bit_cnt_reg, bit_cnt_next;
    logic [COUNT_W-1:0]         done_cnt_reg, done_cnt_next;
    logic [COUNT_W-1:0]         target_reg, target_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] tare_reg, tare_next;
    logic signed [DVD_W-1:0]    q8_reg, q8_next;

    // Results
    logic signed [RAW_W-1:0]    avg_res_reg, avg_res_next;
    logic signed [WEIGHT_W-1:0] wt_res_reg, wt_res_next;
    logic                       err_res_reg, err_res_next;

    // Divider connection
    logic                       div_start;
    logic signed [DVD_W-1:0]    div_dividend;
    logic signed [CAL_W-1:0]    div_divisor;
    logic signed [DVD_W-1:0]    div_quot;
    logic                       div_done;

    logic [COUNT_W-1:0]         req_count;
    logic signed [DVD_W-1:0]    avg_full;
    logic signed [EXT_W-1:0]    quot_ext;

    lcar_div #(
        .W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Select the operands of the two divisions
    assign div_start = cmd.q8_go | cmd.wt_go;
    always_comb
    begin
        if (cmd.wt_go)
        begin
            div_dividend = q8_reg - (DVD_W'(tare_reg) <<< 8);
            div_divisor  = cal_reg;
        end
        else
        begin
            div_dividend = DVD_W'(sum_reg) <<< 8;
            div_divisor  = $signed({{(CAL_W - COUNT_W){1'b0}}, target_reg});
        end
    end

    // Truncated average from the Q8 average, rounding towards zero
    assign avg_full = (div_quot + (div_quot[DVD_W-1] ? DVD_W'(255) : DVD_W'(0))) >>> 8;
    assign quot_ext = EXT_W'(div_quot);

    // Conversion count of the new request, a zero count counts as one
    always_comb
    begin
        if (cmd.req == ACT_MEASURE)
            req_count = scount_reg;
        else if (cmd.req == ACT_TARE)
            req_count = tcount_reg;
        else
            req_count = COUNT_W'(1);
        if (req_count == '0)
            req_count = COUNT_W'(1);
    end

    always_comb
    begin
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        done_cnt_next = done_cnt_reg;
        target_next   = target_reg;
        sum_next      = sum_reg;
        tare_next     = tare_reg;
        q8_next       = q8_reg;
        avg_res_next  = avg_res_reg;
        wt_res_next   = wt_res_reg;
        err_res_next  = err_res_reg;

        // Open a request
        if (cmd.start)
        begin
            target_next   = req_count;
            done_cnt_next = '0;
            sum_next      = '0;
            bit_cnt_next  = '0;
            shift_next    = '0;
        end
        // Open a conversion frame
        if (cmd.frame)
        begin
            bit_cnt_next = '0;
            shift_next   = '0;
        end
        // Sample a data bit, MSB first
        if (cmd.bit_step)
        begin
            if (bit_cnt_reg < BC_W'(SAMPLE_BITS))
                shift_next = {shift_reg[SAMPLE_BITS-2:0], data_level};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        // Add the finished conversion
        if (cmd.accum)
        begin
            sum_next      = sum_reg + SUM_W'($signed(shift_reg));
            done_cnt_next = done_cnt_reg + 1'b1;
        end
        // Take the Q8 average
        if (cmd.take_q8)
        begin
            q8_next      = div_quot;
            avg_res_next = avg_full[RAW_W-1:0];
        end
        if (cmd.set_tare)
            tare_next = avg_full[SAMPLE_BITS-1:0];
        if (cmd.set_zero)
        begin
            err_res_next = 1'b1;
            wt_res_next  = '0;
        end
        // Saturate the weight
        if (cmd.take_wt)
        begin
            err_res_next = 1'b0;
            if (quot_ext > W_MAX)
                wt_res_next = W_MAX[WEIGHT_W-1:0];
            else if (quot_ext < W_MIN)
                wt_res_next = W_MIN[WEIGHT_W-1:0];
            else
                wt_res_next = quot_ext[WEIGHT_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg    <= CAL_RESET;
            scount_reg <= SCOUNT_RESET;
            tcount_reg <= TCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL:    cal_reg    <= $signed(cfg_data[CAL_W-1:0]);
                REG_SCOUNT: scount_reg <= cfg_data[COUNT_W-1:0];
                REG_TCOUNT: tcount_reg <= cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Request state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            bit_cnt_reg  <= '0;
            done_cnt_reg <= '0;
            target_reg   <= COUNT_W'(1);
            sum_reg      <= '0;
            tare_reg     <= '0;
            avg_res_reg  <= '0;
            wt_res_reg   <= '0;
            err_res_reg  <= 1'b0;
        end
        else
        begin
            shift_reg    <= shift_next;
            bit_cnt_reg  <= bit_cnt_next;
            done_cnt_reg <= done_cnt_next;
            target_reg   <= target_next;
            sum_reg      <= sum_next;
            tare_reg     <= tare_next;
            avg_res_reg  <= avg_res_next;
            wt_res_reg   <= wt_res_next;
            err_res_reg  <= err_res_next;
        end
    end

    // Intermediate Q8 average
    always_ff @(posedge clk)
    begin
        q8_reg <= q8_next;
    end

    // Status to the controller
    assign stat.bit_last    = (bit_cnt_reg == BC_W'(SAMPLE_BITS));
    assign stat.sample_last = (({1'b0, done_cnt_reg} + 1'b1) >= {1'b0, target_reg});
    assign stat.div_done    = div_done;
    assign stat.cal_zero    = (cal_reg == '0);

    assign raw_average  = avg_res_reg;
    assign weight       = wt_res_reg;
    assign divide_error = err_res_reg;

endmodule

[rtl/lcar_ctrl.sv]
`timescale 1ns / 1ps

module lcar_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          data_level,
    input  logic [lcar_pkg::ACT_W-1:0]    action,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          clock_level,
    output logic                          busy_res,
    output logic                          done_res,
    output lcar_pkg::dp_cmd_t             cmd,
    input  lcar_pkg::dp_stat_t            stat
);
    import lcar_pkg::*;

    phase_t             phase_reg, phase_next;
    seq_t               seq_reg, seq_next;
    logic [ACT_W-1:0]   req_reg, req_next;
    logic               ovalid_reg, ovalid_next;
    logic               oclk_reg, oclk_next;
    logic               obusy_reg, obusy_next;
    logic               odone_reg, odone_next;

    logic               accept;
    logic               load;
    logic               t_clk;
    logic               t_done;
    logic               t_defer;

    // Take a request only in tick handling, when the output register is free or draining
    assign in_stall = !((seq_reg == SQ_TICK) && (!ovalid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        req_next   = req_reg;
        cmd        = '0;
        cmd.req    = action;
        t_clk      = 1'b0;
        t_done     = 1'b0;
        t_defer    = 1'b0;
        load       = 1'b0;

        unique case (seq_reg)
            SQ_TICK:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (action == ACT_MEASURE || action == ACT_TARE
                                || action == ACT_UP)
                            begin
                                cmd.start  = 1'b1;
                                req_next   = action;
                                phase_next = PH_WAIT;
                            end
                            else if (action == ACT_DOWN)
                            begin
                                phase_next = PH_DOWN;
                                t_clk      = 1'b1;
                                t_done     = 1'b1;
                            end
                        end
                        PH_DOWN:
                        begin
                            if (action == ACT_UP)
                            begin
                                cmd.start  = 1'b1;
                                req_next   = action;
                                phase_next = PH_WAIT;
                            end
                            else
                                t_clk = 1'b1;
                        end
                        PH_WAIT:
                        begin
                            if (!data_level)
                            begin
                                cmd.frame  = 1'b1;
                                phase_next = PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            t_clk      = 1'b1;
                            phase_next = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            cmd.bit_step = 1'b1;
                            if (stat.bit_last)
                            begin
                                cmd.accum = 1'b1;
                                if (stat.sample_last)
                                begin
                                    phase_next = PH_IDLE;
                                    t_done     = 1'b1;
                                    // Measure and tare finish after their divisions
                                    if (req_reg == ACT_MEASURE || req_reg == ACT_TARE)
                                    begin
                                        t_defer  = 1'b1;
                                        seq_next = SQ_Q8_GO;
                                    end
                                end
                                else
                                    phase_next = PH_WAIT;
                            end
                            else
                                phase_next = PH_HIGH;
                        end
                        default: ;
                    endcase
                    load = !t_defer;
                end
            end
            SQ_Q8_GO:
            begin
                cmd.q8_go = 1'b1;
                seq_next  = SQ_Q8_RUN;
            end
            SQ_Q8_RUN:
            begin
                if (stat.div_done)
                begin
                    cmd.take_q8 = 1'b1;
                    t_done      = 1'b1;
                    if (req_reg == ACT_TARE)
                    begin
                        cmd.set_tare = 1'b1;
                        load         = 1'b1;
                        seq_next     = SQ_TICK;
                    end
                    else if (stat.cal_zero)
                    begin
                        cmd.set_zero = 1'b1;
                        load         = 1'b1;
                        seq_next     = SQ_TICK;
                    end
                    else
                        seq_next = SQ_WT_GO;
                end
            end
            SQ_WT_GO:
            begin
                cmd.wt_go = 1'b1;
                seq_next  = SQ_WT_RUN;
            end
            SQ_WT_RUN:
            begin
                if (stat.div_done)
                begin
                    cmd.take_wt = 1'b1;
                    t_done      = 1'b1;
                    load        = 1'b1;
                    seq_next    = SQ_TICK;
                end
            end
            default: ;
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        oclk_next   = oclk_reg;
        obusy_next  = obusy_reg;
        odone_next  = odone_reg;
        if (load)
        begin
            ovalid_next = 1'b1;
            oclk_next   = t_clk;
            obusy_next  = (phase_next == PH_WAIT) || (phase_next == PH_HIGH)
                          || (phase_next == PH_LOW);
            odone_next  = t_done;
        end
        else if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            seq_reg    <= SQ_TICK;
            req_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            req_reg    <= req_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        oclk_reg  <= oclk_next;
        obusy_reg <= obusy_next;
        odone_reg <= odone_next;
    end

    assign out_valid   = ovalid_reg;
    assign clock_level = oclk_reg;
    assign busy_res    = obusy_reg;
    assign done_res    = odone_reg;

endmodule

[rtl/load_cell_adc_reader_scaler.sv]
`timescale 1ns / 1ps

// Load cell converter reader and scaler.
// Input channel: one request per half-clock tick of the converter's serial
// clock, carrying the sampled data pin (data_level) and an action code
// (measure, tare, power down, power up, anything else is none).
// Output channel: one request per input tick, giving the serial clock level
// to drive, busy and done flags, and the last average, weight and error.
// Configuration: cfg_we writes calibration, sample count or tare count at
// cfg_index; writes are meant only while the block is idle.
// Flow: an ordinary tick appears on the output in the cycle after it is
// taken, and a new tick can be taken every cycle while the output drains
// and no division runs. The tick that completes a tare runs one division
// of SAMPLE_BITS+17 steps; one that completes a measure runs two, or one
// when the calibration is zero. Both share the one bit-serial divider.
// While the receiver stalls a valid output, the output register holds and in_stall stays
// high. Reset leaves the block idle and powered up, results zero, and the
// registers at calibration -781, sample count 10 and tare count 20.
module load_cell_adc_reader_scaler #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  data_level,
    input  logic [lcar_pkg::ACT_W-1:0]            action,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  clock_level,
    output logic                                  busy_res,
    output logic                                  done_res,
    output logic signed [lcar_pkg::RAW_W-1:0]     raw_average,
    output logic signed [lcar_pkg::WEIGHT_W-1:0]  weight,
    output logic                                  divide_error,
    input  logic                                  cfg_we,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lcar_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing and converter protocol
    lcar_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_level  (data_level),
        .action      (action),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .clock_level (clock_level),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Sampling, accumulation and scaling
    lcar_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_level   (data_level),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .raw_average  (raw_average),
        .weight       (weight),
        .divide_error (divide_error)
    );

endmodule
